@@ sv/aabb_pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// aabb_pcs_pkg
// Types and constants shared by the box pair collision scan core.
// ----------------------------------------------------------------------------
package aabb_pcs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int SLOT_W        = 6;
    localparam int COORD_W       = 16;

    localparam logic [15:0] TYPE_PAIR_MASK_RESET = 16'd4940;

    // Request kinds; the fourth code is ignored.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [SLOT_W-1:0]          slot;
        logic [1:0]                 box_type;
        logic                       box_enabled;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]         size_w;
        logic [COORD_W-1:0]         size_h;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              last;
    } t_res;

    // One box as held in the table.
    typedef struct packed {
        logic                       valid;
        logic                       enabled;
        logic [1:0]                 box_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]         size_w;
        logic [COORD_W-1:0]         size_h;
    } t_box;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

@@ sv/aabb_pcs_box_store.sv @@
// ----------------------------------------------------------------------------
// aabb_pcs_box_store
// Box table: position and attribute memories with one write and one
// registered read port, plus a valid flag per slot cleared by reset.
// ----------------------------------------------------------------------------
module aabb_pcs_box_store #(
    parameter int MAX_BOXES = aabb_pcs_pkg::MAX_BOXES_DEF,
    parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic                 i_clr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  aabb_pcs_pkg::t_req   i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output aabb_pcs_pkg::t_box   o_rd_box
);

    localparam int PW = 2 * aabb_pcs_pkg::COORD_W;
    localparam int XW = 3 + 2 * aabb_pcs_pkg::COORD_W;

    logic [PW-1:0]        r_pos_mem [MAX_BOXES];
    logic [XW-1:0]        r_attr_mem [MAX_BOXES];
    logic [MAX_BOXES-1:0] r_valid;

    logic [PW-1:0] r_pos_rd;
    logic [XW-1:0] r_attr_rd;
    logic          r_valid_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pos_mem[i_wr_addr]  <= {i_wr_data.pos_x, i_wr_data.pos_y};
            r_attr_mem[i_wr_addr] <= {i_wr_data.box_enabled, i_wr_data.box_type,
                                      i_wr_data.size_w, i_wr_data.size_h};
        end
        if (i_rd_en) begin
            r_pos_rd  <= r_pos_mem[i_rd_addr];
            r_attr_rd <= r_attr_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_valid_rd <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_valid_rd <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_box          = '0;
        o_rd_box.valid    = r_valid_rd;
        o_rd_box.enabled  = r_attr_rd[XW-1];
        o_rd_box.box_type = r_attr_rd[XW-2:XW-3];
        o_rd_box.size_w   = r_attr_rd[2*aabb_pcs_pkg::COORD_W-1:aabb_pcs_pkg::COORD_W];
        o_rd_box.size_h   = r_attr_rd[aabb_pcs_pkg::COORD_W-1:0];
        o_rd_box.pos_x    = r_pos_rd[PW-1:aabb_pcs_pkg::COORD_W];
        o_rd_box.pos_y    = r_pos_rd[aabb_pcs_pkg::COORD_W-1:0];
    end

endmodule

@@ sv/aabb_pcs_overlap_unit.sv @@
// ----------------------------------------------------------------------------
// aabb_pcs_overlap_unit
// Collision test of one box pair: enables, type mask and edge compares.
// ----------------------------------------------------------------------------
module aabb_pcs_overlap_unit (
    input  aabb_pcs_pkg::t_box i_box_a,
    input  aabb_pcs_pkg::t_box i_box_b,
    input  logic [15:0]        i_type_pair_mask,
    output logic               o_collide
);

    logic signed [17:0] a_x, a_y, b_x, b_y;
    logic signed [17:0] a_x_end, a_y_end, b_x_end, b_y_end;
    logic               type_ok;
    logic               x_ok, y_ok;

    always_comb begin
        a_x     = {{2{i_box_a.pos_x[15]}}, i_box_a.pos_x};
        a_y     = {{2{i_box_a.pos_y[15]}}, i_box_a.pos_y};
        b_x     = {{2{i_box_b.pos_x[15]}}, i_box_b.pos_x};
        b_y     = {{2{i_box_b.pos_y[15]}}, i_box_b.pos_y};
        a_x_end = a_x + $signed({2'b00, i_box_a.size_w});
        a_y_end = a_y + $signed({2'b00, i_box_a.size_h});
        b_x_end = b_x + $signed({2'b00, i_box_b.size_w});
        b_y_end = b_y + $signed({2'b00, i_box_b.size_h});
        type_ok = i_type_pair_mask[{i_box_a.box_type, i_box_b.box_type}];
        // Touching counts as a hit on y only at the end edge (pos_y + size_h) of the first box.
        x_ok    = (a_x < b_x_end) && (a_x_end > b_x);
        y_ok    = (a_y < b_y_end) && (a_y_end >= b_y);
        o_collide = i_box_a.enabled && i_box_b.enabled && type_ok && x_ok && y_ok;
    end

endmodule

@@ sv/aabb_pair_collision_scan_core.sv @@
// ----------------------------------------------------------------------------
// aabb_pair_collision_scan_core
// Broad-phase collision scan over a table of axis-aligned boxes.
// ----------------------------------------------------------------------------
// A write request and a clear request are each done in the cycle that accepts
// them. A scan of a valid slot i goes through the accepting cycle, the fetch
// of box i, a read of each later slot in turn through the single read port of
// the box table, and the closing result. A scan of an empty slot stops straight
// after the fetch, and a scan of a slot beyond the table goes directly to the
// closing result. A stalled result channel holds the walk whenever a further
// hit is found while one hit is held back and the output register still holds
// a result that has not been taken, and the closing result waits in the same
// way. The request channel is ready only between scans. There is no clearing
// pass after reset, since the slot valid flags are flip-flops that reset
// clears at once.
module aabb_pair_collision_scan_core #(
    parameter int MAX_BOXES = aabb_pcs_pkg::MAX_BOXES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  aabb_pcs_pkg::t_req i_req,
    // Result channel.
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output aabb_pcs_pkg::t_res o_res,
    // Type pair mask write.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [AW:0] CNT_MAX = (AW + 1)'(MAX_BOXES);
    localparam logic [aabb_pcs_pkg::SLOT_W:0] SLOT_LIMIT =
        (aabb_pcs_pkg::SLOT_W + 1)'(MAX_BOXES);

    aabb_pcs_pkg::t_state r_state, n_state;

    logic [15:0]                     r_mask;
    logic [aabb_pcs_pkg::SLOT_W-1:0] r_first, n_first;
    aabb_pcs_pkg::t_box              r_box_a, n_box_a;
    logic [AW:0]                     r_next_j, n_next_j;
    logic [AW-1:0]                   r_cmp_j, n_cmp_j;
    logic                            r_pend_valid, n_pend_valid;
    logic [AW-1:0]                   r_pend_j, n_pend_j;
    logic                            r_out_valid, n_out_valid;
    aabb_pcs_pkg::t_res              r_out, n_out;

    logic               req_fire;
    logic               slot_in_range;
    logic               wr_en, clr_en, rd_en;
    logic [AW-1:0]      rd_addr;
    aabb_pcs_pkg::t_box rd_box;
    logic               collide;
    logic               hit_now;
    logic               out_free;

    // The table itself: one write port for write and clear requests, one
    // registered read port that the scan walks slot by slot.
    aabb_pcs_box_store #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_clr_en  (clr_en),
        .i_wr_addr (i_req.slot[AW-1:0]),
        .i_wr_data (i_req),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_box  (rd_box)
    );

    // The shared pair tester compares the held scanned box with whichever
    // box the read port has just delivered.
    aabb_pcs_overlap_unit u_overlap (
        .i_box_a          (r_box_a),
        .i_box_b          (rd_box),
        .i_type_pair_mask (r_mask),
        .o_collide        (collide)
    );

    assign o_req_ready   = (r_state == aabb_pcs_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_res_valid   = r_out_valid;
    assign o_res         = r_out;
    assign req_fire      = i_req_valid && o_req_ready;
    assign slot_in_range = ({1'b0, i_req.slot} < SLOT_LIMIT);
    assign out_free      = !r_out_valid || i_res_ready;
    assign hit_now       = rd_box.valid && collide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aabb_pcs_pkg::ST_IDLE;
            r_mask       <= aabb_pcs_pkg::TYPE_PAIR_MASK_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_box_a  <= n_box_a;
        r_next_j <= n_next_j;
        r_cmp_j  <= n_cmp_j;
        r_pend_j <= n_pend_j;
        r_out    <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        n_box_a      = r_box_a;
        n_next_j     = r_next_j;
        n_cmp_j      = r_cmp_j;
        n_pend_valid = r_pend_valid;
        n_pend_j     = r_pend_j;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out        = r_out;
        wr_en        = 1'b0;
        clr_en       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_next_j[AW-1:0];

        unique case (r_state)
            aabb_pcs_pkg::ST_IDLE: begin
                rd_addr = i_req.slot[AW-1:0];
                if (req_fire) begin
                    unique case (i_req.kind)
                        aabb_pcs_pkg::KIND_WRITE: wr_en  = slot_in_range;
                        aabb_pcs_pkg::KIND_CLEAR: clr_en = slot_in_range;
                        aabb_pcs_pkg::KIND_SCAN: begin
                            n_first      = i_req.slot;
                            n_pend_valid = 1'b0;
                            n_next_j     = (AW + 1)'(i_req.slot[AW-1:0]) + 1'b1;
                            if (slot_in_range) begin
                                rd_en   = 1'b1;
                                n_state = aabb_pcs_pkg::ST_LOAD_A;
                            end else begin
                                n_state = aabb_pcs_pkg::ST_FINISH;
                            end
                        end
                        default: begin
                            // The unused kind is dropped without a result.
                        end
                    endcase
                end
            end

            aabb_pcs_pkg::ST_LOAD_A: begin
                // The scanned box arrives; an empty slot ends the scan at once.
                n_box_a = rd_box;
                if (rd_box.valid && (r_next_j < CNT_MAX)) begin
                    rd_en    = 1'b1;
                    n_cmp_j  = r_next_j[AW-1:0];
                    n_next_j = r_next_j + 1'b1;
                    n_state  = aabb_pcs_pkg::ST_SCAN;
                end else begin
                    n_state = aabb_pcs_pkg::ST_FINISH;
                end
            end

            aabb_pcs_pkg::ST_SCAN: begin
                // A hit is held back until the next one is found, so that the
                // final hit can carry the last flag. Pushing the held hit needs
                // a free output register; otherwise the walk waits here with
                // the read data frozen.
                if (!(hit_now && r_pend_valid && !out_free)) begin
                    if (hit_now) begin
                        if (r_pend_valid) begin
                            n_out_valid       = 1'b1;
                            n_out.hit         = 1'b1;
                            n_out.first_slot  = r_first;
                            n_out.second_slot = aabb_pcs_pkg::SLOT_W'(r_pend_j);
                            n_out.last        = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_j     = r_cmp_j;
                    end
                    if (r_next_j < CNT_MAX) begin
                        rd_en    = 1'b1;
                        n_cmp_j  = r_next_j[AW-1:0];
                        n_next_j = r_next_j + 1'b1;
                    end else begin
                        n_state = aabb_pcs_pkg::ST_FINISH;
                    end
                end
            end

            aabb_pcs_pkg::ST_FINISH: begin
                // Close the scan with the held hit, or with the no-hit result.
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.first_slot = r_first;
                    n_out.last       = 1'b1;
                    if (r_pend_valid) begin
                        n_out.hit         = 1'b1;
                        n_out.second_slot = aabb_pcs_pkg::SLOT_W'(r_pend_j);
                    end else begin
                        n_out.hit         = 1'b0;
                        n_out.second_slot = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = aabb_pcs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = aabb_pcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
